### rtl/dgsp_pkg.sv
package dgsp_pkg;

    localparam int NODES_DEF   = 64;
    localparam int NODE_W      = 6;
    localparam int DIST_W      = 17;
    localparam int CMD_W       = 2;
    localparam int CNT_W       = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 7;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;

    localparam logic [DIST_W-1:0] NO_EDGE = 17'd99999;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_NODE = 1'd1;

    localparam logic [CNT_W-1:0] NODE_COUNT_RESET = 7'd64;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_SCAN_END,
        ST_PICK,
        ST_RELAX,
        ST_RELAX_END,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    typedef struct packed {
        logic sweep_we;
        logic load_we;
        logic init_we;
        logic scan_start;
        logic scan_rd;
        logic mark;
        logic relax_rd;
        logic emit_rd;
        logic emit_ld;
        logic emit_last;
    } t_ctl;

    typedef struct packed {
        logic found;
        logic out_busy;
    } t_stat;

endpackage

### rtl/dense_graph_shortest_paths.sv
// Channel   Direction  Handshake                      Contents
// s_axis    in         s_axis_tvalid / s_axis_tready  cmd in tuser; from_node, to_node, weight
// m_axis    out        m_axis_tvalid / m_axis_tready  node, distance; tlast on final node
// cfg       in         i_cfg_we                       node_count (index 0), source_node (1)
//
// Load and unused commands leave the block idle and ready. Clear writes one
// matrix entry per cycle through the single write port of the edge memory.
// In a run, each selection round scans the distance memory once and relaxes
// one matrix row once. After reset the edge memory is cleared with
// s_axis_tready low. A stalled m_axis holds the run; each result word waits
// in the output register.
module dense_graph_shortest_paths #(
    parameter int NODES = dgsp_pkg::NODES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // from_node[5:0], to_node[11:6], weight[28:12], zero[31:29]
    input  logic [dgsp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // cmd[1:0]
    input  logic [dgsp_pkg::CMD_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // node[5:0], distance[22:6], zero[23]
    output logic [dgsp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_we,
    input  logic [dgsp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dgsp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import dgsp_pkg::*;

    localparam int NW = $clog2(NODES);
    localparam int AW = $clog2(NODES*NODES);

    t_ctl              ctl;
    t_stat             stat;
    logic [NW-1:0]     idx;
    logic [AW-1:0]     sweep_addr;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] out_node;
    logic [DIST_W-1:0] out_distance;

    dgsp_ctrl #(.NODES(NODES)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_cmd     (s_axis_tuser),
        .o_in_ready   (s_axis_tready),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_stat       (stat),
        .o_ctl        (ctl),
        .o_idx        (idx),
        .o_sweep_addr (sweep_addr),
        .o_src        (src)
    );

    dgsp_dpath #(.NODES(NODES)) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_idx          (idx),
        .i_sweep_addr   (sweep_addr),
        .i_src          (src),
        .i_from         (s_axis_tdata[0 +: NODE_W]),
        .i_to           (s_axis_tdata[NODE_W +: NODE_W]),
        .i_weight       (s_axis_tdata[2*NODE_W +: DIST_W]),
        .i_out_ready    (m_axis_tready),
        .o_stat         (stat),
        .o_out_valid    (m_axis_tvalid),
        .o_out_node     (out_node),
        .o_out_distance (out_distance),
        .o_out_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-NODE_W-DIST_W){1'b0}}, out_distance, out_node};

endmodule

### rtl/dgsp_ctrl.sv
module dgsp_ctrl #(
    parameter int NODES = dgsp_pkg::NODES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic [dgsp_pkg::CMD_W-1:0]       i_in_cmd,
    output logic                             o_in_ready,
    input  logic                             i_cfg_we,
    input  logic [dgsp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dgsp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  dgsp_pkg::t_stat                  i_stat,
    output dgsp_pkg::t_ctl                   o_ctl,
    output logic [$clog2(NODES)-1:0]         o_idx,
    output logic [$clog2(NODES*NODES)-1:0]   o_sweep_addr,
    output logic [dgsp_pkg::NODE_W-1:0]      o_src
);
    import dgsp_pkg::*;

    localparam int NW = $clog2(NODES);
    localparam int AW = $clog2(NODES*NODES);
    localparam int CW = $clog2(NODES+1);
    localparam logic [AW-1:0] SWEEP_LAST = AW'(NODES*NODES-1);

    t_state            r_state, n_state;
    logic [NW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_sweep, n_sweep;
    logic [CW-1:0]     r_n, n_n;
    logic [CW-1:0]     r_left, n_left;
    logic [CNT_W-1:0]  r_node_count;
    logic [NODE_W-1:0] r_source;

    logic [CW-1:0] clamp_n;
    logic          idx_last;
    logic          src_ok;

    always_comb begin
        if (r_node_count == '0) begin
            clamp_n = CW'(1);
        end else if (r_node_count > CNT_W'(NODES)) begin
            clamp_n = CW'(NODES);
        end else begin
            clamp_n = CW'(r_node_count);
        end
    end

    assign idx_last = (CW'(r_idx) == (r_n - CW'(1)));
    assign src_ok   = (CNT_W'(r_source) < CNT_W'(r_n));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_idx        <= '0;
            r_sweep      <= '0;
            r_n          <= CW'(1);
            r_left       <= '0;
            r_node_count <= NODE_COUNT_RESET;
            r_source     <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_sweep <= n_sweep;
            r_n     <= n_n;
            r_left  <= n_left;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_NODE_COUNT:  r_node_count <= i_cfg_data[CNT_W-1:0];
                    REG_SOURCE_NODE: r_source     <= i_cfg_data[NODE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_sweep    = r_sweep;
        n_n        = r_n;
        n_left     = r_left;
        o_ctl      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_SWEEP: begin
                o_ctl.sweep_we = 1'b1;
                if (r_sweep == SWEEP_LAST) begin
                    n_sweep = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_sweep = r_sweep + AW'(1);
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (i_in_cmd)
                        CMD_CLEAR: n_state = ST_SWEEP;
                        CMD_LOAD:  o_ctl.load_we = 1'b1;
                        CMD_RUN: begin
                            n_n     = clamp_n;
                            n_idx   = '0;
                            n_state = ST_INIT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_INIT: begin
                o_ctl.init_we = 1'b1;
                if (idx_last) begin
                    n_idx = '0;
                    if (src_ok && (r_n > CW'(1))) begin
                        n_left           = r_n - CW'(1);
                        o_ctl.scan_start = 1'b1;
                        n_state          = ST_SCAN;
                    end else begin
                        n_state = ST_EMIT_RD;
                    end
                end else begin
                    n_idx = r_idx + NW'(1);
                end
            end
            ST_SCAN: begin
                o_ctl.scan_rd = 1'b1;
                if (idx_last) begin
                    n_idx   = '0;
                    n_state = ST_SCAN_END;
                end else begin
                    n_idx = r_idx + NW'(1);
                end
            end
            ST_SCAN_END: begin
                n_state = ST_PICK;
            end
            ST_PICK: begin
                if (i_stat.found) begin
                    o_ctl.mark = 1'b1;
                    n_state    = ST_RELAX;
                end else begin
                    n_state = ST_EMIT_RD;
                end
            end
            ST_RELAX: begin
                o_ctl.relax_rd = 1'b1;
                if (idx_last) begin
                    n_idx   = '0;
                    n_state = ST_RELAX_END;
                end else begin
                    n_idx = r_idx + NW'(1);
                end
            end
            ST_RELAX_END: begin
                n_left = r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    n_state = ST_EMIT_RD;
                end else begin
                    o_ctl.scan_start = 1'b1;
                    n_state          = ST_SCAN;
                end
            end
            ST_EMIT_RD: begin
                o_ctl.emit_rd = 1'b1;
                n_state       = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (!i_stat.out_busy) begin
                    o_ctl.emit_ld   = 1'b1;
                    o_ctl.emit_last = idx_last;
                    if (idx_last) begin
                        n_idx   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + NW'(1);
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_idx        = r_idx;
    assign o_sweep_addr = r_sweep;
    assign o_src        = r_source;

    a_run_starts_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_in_cmd == CMD_RUN)) |=> (r_state == ST_INIT))
        else $error("accepted run did not start initialization");

    a_no_pick_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_PICK) && !i_stat.found) |=> (r_state == ST_EMIT_RD))
        else $error("run did not stop when no reachable node was left");

endmodule

### rtl/dgsp_dpath.sv
module dgsp_dpath #(
    parameter int NODES = dgsp_pkg::NODES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dgsp_pkg::t_ctl                   i_ctl,
    input  logic [$clog2(NODES)-1:0]         i_idx,
    input  logic [$clog2(NODES*NODES)-1:0]   i_sweep_addr,
    input  logic [dgsp_pkg::NODE_W-1:0]      i_src,
    input  logic [dgsp_pkg::NODE_W-1:0]      i_from,
    input  logic [dgsp_pkg::NODE_W-1:0]      i_to,
    input  logic [dgsp_pkg::DIST_W-1:0]      i_weight,
    input  logic                             i_out_ready,
    output dgsp_pkg::t_stat                  o_stat,
    output logic                             o_out_valid,
    output logic [dgsp_pkg::NODE_W-1:0]      o_out_node,
    output logic [dgsp_pkg::DIST_W-1:0]      o_out_distance,
    output logic                             o_out_last
);
    import dgsp_pkg::*;

    localparam int NW = $clog2(NODES);
    localparam int AW = $clog2(NODES*NODES);

    // Each distance entry carries its done mark in the top bit.
    logic [DIST_W-1:0] r_edge_mem [NODES*NODES];
    logic [DIST_W:0]   r_dist_mem [NODES];
    logic [DIST_W-1:0] r_edge_rd;
    logic [DIST_W:0]   r_dist_rd;
    logic              r_scan_v;
    logic              r_rel_v;
    logic [NW-1:0]     r_j;
    logic [DIST_W-1:0] r_least;
    logic [NW-1:0]     r_pick;
    logic              r_found;
    logic              r_out_valid;
    logic [NODE_W-1:0] r_out_node;
    logic [DIST_W-1:0] r_out_distance;
    logic              r_out_last;

    logic              load_ok;
    logic              edge_we;
    logic [AW-1:0]     edge_wa;
    logic [DIST_W-1:0] edge_wd;
    logic [AW-1:0]     load_addr;
    logic [AW-1:0]     rel_addr;
    logic              dist_we;
    logic [NW-1:0]     dist_wa;
    logic [DIST_W:0]   dist_wd;
    logic              dist_re;
    logic              rd_done;
    logic [DIST_W-1:0] rd_dist;
    logic              scan_hit;
    logic [DIST_W:0]   cand;
    logic              rel_we;

    assign load_ok   = (CNT_W'(i_from) < CNT_W'(NODES)) && (CNT_W'(i_to) < CNT_W'(NODES));
    assign load_addr = AW'(i_from) * AW'(NODES) + AW'(i_to);
    assign rel_addr  = AW'(r_pick) * AW'(NODES) + AW'(i_idx);
    assign edge_we   = i_ctl.sweep_we || (i_ctl.load_we && load_ok);
    assign edge_wa   = i_ctl.sweep_we ? i_sweep_addr : load_addr;
    assign edge_wd   = (i_ctl.sweep_we || (i_weight > NO_EDGE)) ? NO_EDGE : i_weight;

    assign rd_done = r_dist_rd[DIST_W];
    assign rd_dist = r_dist_rd[DIST_W-1:0];

    assign cand   = {1'b0, r_least} + {1'b0, r_edge_rd};
    assign rel_we = r_rel_v && !rd_done && (r_edge_rd != NO_EDGE)
                    && (cand < {1'b0, rd_dist});
    assign scan_hit = r_scan_v && !rd_done && (rd_dist < r_least);

    assign dist_we = i_ctl.init_we || i_ctl.mark || rel_we;
    assign dist_re = i_ctl.scan_rd || i_ctl.relax_rd || i_ctl.emit_rd;

    always_comb begin
        if (i_ctl.init_we) begin
            dist_wa = i_idx;
            if (NODE_W'(i_idx) == i_src) begin
                dist_wd = '0;
            end else begin
                dist_wd = {1'b0, NO_EDGE};
            end
        end else if (i_ctl.mark) begin
            dist_wa = r_pick;
            dist_wd = {1'b1, r_least};
        end else begin
            dist_wa = r_j;
            dist_wd = {1'b0, cand[DIST_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            r_edge_mem[edge_wa] <= edge_wd;
        end
        if (i_ctl.relax_rd) begin
            r_edge_rd <= r_edge_mem[rel_addr];
        end
        if (dist_we) begin
            r_dist_mem[dist_wa] <= dist_wd;
        end
        if (dist_re) begin
            r_dist_rd <= r_dist_mem[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        r_j <= i_idx;
        if (i_ctl.scan_start) begin
            r_least <= NO_EDGE;
        end else if (scan_hit) begin
            r_least <= rd_dist;
            r_pick  <= r_j;
        end
        if (i_ctl.emit_ld) begin
            r_out_node     <= NODE_W'(i_idx);
            r_out_distance <= rd_dist;
            r_out_last     <= i_ctl.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_v    <= 1'b0;
            r_rel_v     <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_scan_v <= i_ctl.scan_rd;
            r_rel_v  <= i_ctl.relax_rd;
            if (i_ctl.scan_start) begin
                r_found <= 1'b0;
            end else if (scan_hit) begin
                r_found <= 1'b1;
            end
            if (i_ctl.emit_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.found    = r_found;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_node      = r_out_node;
    assign o_out_distance  = r_out_distance;
    assign o_out_last      = r_out_last;

    a_pick_reachable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.mark |-> (r_found && (r_least < NO_EDGE)))
        else $error("selected node has no finite distance");

    a_one_dist_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_ctl.init_we, i_ctl.mark, rel_we}))
        else $error("two distance writes in one cycle");

    a_emit_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.emit_ld |-> (!r_out_valid || i_out_ready))
        else $error("result overwrote a word not yet taken");

endmodule

### dv/dense_graph_shortest_paths_tb.sv
`timescale 1ns / 100ps

module dense_graph_shortest_paths_tb;
    import dgsp_pkg::*;

    localparam int NODES          = NODES_DEF;
    localparam int SETTLE_CYCLES  = NODES * NODES + 200;
    localparam int TAIL_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 60000;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [DIST_W-1:0] weight;
        logic [NODE_W-1:0] to_node;
        logic [NODE_W-1:0] from_node;
        logic [CMD_W-1:0]  cmd;
    } t_graph_cmd;

    typedef struct packed {
        logic              last;
        logic [DIST_W-1:0] distance;
        logic [NODE_W-1:0] node;
    } t_dist_word;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0]       s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    t_graph_cmd        pending_cmds[$];
    t_dist_word        pending_dists[$];
    t_graph_cmd        cur_cmd;
    logic [DIST_W-1:0] edge_w [NODES*NODES];
    logic [CNT_W-1:0]  cfg_node_count = NODE_COUNT_RESET;
    logic [NODE_W-1:0] cfg_source = '0;

    int burst_left = 1;
    int send_gap = 0;
    int rdy_hold = 0;
    int idle_cycles = 0;
    int fail_cnt = 0;
    int words_in = 0;
    int words_out = 0;
    int run_cnt = 0;
    int clear_cnt = 0;

    dense_graph_shortest_paths u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Dijkstra over the first n nodes; queues one distance word per node.
    function automatic void predict_run();
        logic [DIST_W-1:0] best [NODES];
        logic              done [NODES];
        logic [DIST_W-1:0] least;
        logic [DIST_W-1:0] w;
        logic [DIST_W:0]   cand;
        t_dist_word        dw;
        int                n;
        int                pick;
        int                r;
        int                j;
        bit                found;
        n = (cfg_node_count == 0) ? 1 : (cfg_node_count > NODES) ? NODES : cfg_node_count;
        for (j = 0; j < NODES; j++) begin
            best[j] = NO_EDGE;
            done[j] = 1'b0;
        end
        if (cfg_source < n) begin
            best[cfg_source] = '0;
            for (r = 0; r + 1 < n; r++) begin
                found = 1'b0;
                least = NO_EDGE;
                pick = 0;
                for (j = 0; j < n; j++) begin
                    if (!done[j] && best[j] < least) begin
                        least = best[j];
                        pick = j;
                        found = 1'b1;
                    end
                end
                if (!found) break;
                done[pick] = 1'b1;
                for (j = 0; j < n; j++) begin
                    w = edge_w[pick*NODES + j];
                    cand = best[pick] + w;
                    if (!done[j] && w != NO_EDGE && cand < best[j]) best[j] = cand[DIST_W-1:0];
                end
            end
        end
        for (j = 0; j < n; j++) begin
            dw.node = j[NODE_W-1:0];
            dw.distance = best[j];
            dw.last = (j == n - 1);
            pending_dists.push_back(dw);
        end
    endfunction

    function automatic void apply_to_graph(input t_graph_cmd c);
        int k;
        case (c.cmd)
            CMD_CLEAR: begin
                for (k = 0; k < NODES*NODES; k++) edge_w[k] = NO_EDGE;
                clear_cnt++;
            end
            CMD_LOAD: begin
                edge_w[c.from_node*NODES + c.to_node] = (c.weight > NO_EDGE) ? NO_EDGE : c.weight;
            end
            CMD_RUN: begin
                predict_run();
                run_cnt++;
            end
            default: begin
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_to_graph(cur_cmd);
                words_in++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    cur_cmd <= pending_cmds[0];
                    s_axis_tuser <= pending_cmds[0].cmd;
                    s_axis_tdata <= {{(IN_TDATA_W-2*NODE_W-DIST_W){1'b0}},
                                     pending_cmds[0].weight, pending_cmds[0].to_node,
                                     pending_cmds[0].from_node};
                    s_axis_tvalid <= 1'b1;
                    void'(pending_cmds.pop_front());
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 16);
                        send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_dist_word got;
        t_dist_word want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.node = m_axis_tdata[NODE_W-1:0];
                got.distance = m_axis_tdata[NODE_W +: DIST_W];
                got.last = m_axis_tlast;
                words_out++;
                if (pending_dists.size() == 0) begin
                    $error("unexpected word: node %0d distance %0d", got.node, got.distance);
                    fail_cnt++;
                end else begin
                    want = pending_dists.pop_front();
                    if (got.node !== want.node) begin
                        $error("node: expected %0d, actual %0d", want.node, got.node);
                        fail_cnt++;
                    end
                    if (got.distance !== want.distance) begin
                        $error("distance: expected %0d, actual %0d", want.distance, got.distance);
                        fail_cnt++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, got.last);
                        fail_cnt++;
                    end
                end
            end
            if (rdy_hold != 0) begin
                rdy_hold <= rdy_hold - 1;
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        m_axis_tready <= 1'b0;
                        rdy_hold <= $urandom_range(1, 8);
                    end
                    1: begin
                        m_axis_tready <= 1'b1;
                        rdy_hold <= $urandom_range(30, 100);
                    end
                    default: begin
                        m_axis_tready <= 1'b1;
                        rdy_hold <= $urandom_range(0, 3);
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_cmd(input logic [CMD_W-1:0] cmd, input int from_n, input int to_n,
                            input int weight);
        t_graph_cmd c;
        c.cmd = cmd;
        c.from_node = from_n[NODE_W-1:0];
        c.to_node = to_n[NODE_W-1:0];
        c.weight = weight[DIST_W-1:0];
        pending_cmds.push_back(c);
    endtask

    task automatic push_noise(input logic [CMD_W-1:0] cmd);
        push_cmd(cmd, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 131071));
    endtask

    task automatic push_random_load(input int n);
        int from_n;
        int to_n;
        int weight;
        from_n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
        to_n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
        case ($urandom_range(0, 9))
            6: weight = 0;
            7: weight = NO_EDGE;
            8: weight = $urandom_range(30000, 99998);
            9: weight = $urandom_range(0, 131071);
            default: weight = $urandom_range(0, 50);
        endcase
        push_cmd(CMD_LOAD, from_n, to_n, weight);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_NODE_COUNT) cfg_node_count = val[CNT_W-1:0];
        else cfg_source = val[NODE_W-1:0];
    endtask

    task automatic set_config(input int count, input int src);
        write_reg(REG_NODE_COUNT, count);
        write_reg(REG_SOURCE_NODE, src);
    endtask

    // The sender holds off here until every distance word has come back.
    task automatic wait_idle(input int settle);
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || s_axis_tvalid || pending_dists.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    initial begin
        int k;
        int ph;
        int nc;
        int src;
        int n_items;
        for (k = 0; k < NODES*NODES; k++) edge_w[k] = NO_EDGE;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(negedge i_clk);
        while (!s_axis_tready);

        set_config(8, 0);
        push_cmd(CMD_UNUSED, 63, 63, 131071);
        push_cmd(CMD_LOAD, 0, 1, 9);
        push_cmd(CMD_LOAD, 0, 2, 10);
        push_cmd(CMD_LOAD, 1, 2, 3);
        push_cmd(CMD_LOAD, 2, 3, 0);
        push_cmd(CMD_LOAD, 3, 4, 99998);
        push_cmd(CMD_LOAD, 5, 6, 131071);
        push_cmd(CMD_LOAD, 1, 5, 4);
        push_cmd(CMD_LOAD, 63, 0, 1);
        push_cmd(CMD_LOAD, 0, 1, 2);
        push_cmd(CMD_LOAD, 1, 1, NO_EDGE);
        push_cmd(CMD_RUN, 0, 0, 0);
        wait_idle(SETTLE_CYCLES);
        set_config(8, 6);
        push_cmd(CMD_RUN, 63, 63, 131071);
        wait_idle(SETTLE_CYCLES);
        set_config(0, 0);
        push_cmd(CMD_RUN, 0, 0, 0);
        wait_idle(SETTLE_CYCLES);
        set_config(100, 63);
        push_cmd(CMD_RUN, 0, 0, 0);
        wait_idle(SETTLE_CYCLES);
        set_config(5, 7);
        push_cmd(CMD_RUN, 0, 0, 0);
        wait_idle(SETTLE_CYCLES);
        set_config(64, 0);
        push_noise(CMD_CLEAR);
        push_cmd(CMD_RUN, 0, 0, 0);

        for (ph = 0; ph < 5; ph++) begin
            wait_idle(SETTLE_CYCLES);
            nc = (ph == 2) ? 64 : $urandom_range(2, 12);
            src = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : $urandom_range(0, nc - 1);
            set_config(nc, src);
            if ($urandom_range(0, 2) == 0) push_noise(CMD_CLEAR);
            n_items = (ph == 2) ? 10 : $urandom_range(14, 22);
            for (k = 0; k < n_items; k++) begin
                case ($urandom_range(0, 19))
                    0: push_noise(CMD_UNUSED);
                    1: push_noise(CMD_RUN);
                    default: push_random_load(nc);
                endcase
            end
            push_noise(CMD_RUN);
        end

        wait_idle(TAIL_CYCLES);
        $display("Sent %0d command words (%0d runs, %0d clears) over several node counts",
                 words_in, run_cnt, clear_cnt);
        $display("and sources; checked %0d distance words.", words_out);
        if (fail_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### sim.f
rtl/dgsp_pkg.sv
rtl/dgsp_ctrl.sv
rtl/dgsp_dpath.sv
rtl/dense_graph_shortest_paths.sv
dv/dense_graph_shortest_paths_tb.sv
